// ===== rtl/core/igfr_pkg.sv =====
// Package for the idle gap frame receiver: sizes, codes, payload structs
// and address helpers. No dependencies.
package igfr_pkg;

    localparam int LINES      = 4;
    localparam int LINE_BYTES = 32;

    localparam int LINE_W  = $clog2(LINES);
    localparam int POS_W   = $clog2(LINE_BYTES + 1);
    localparam int USED_W  = $clog2(LINES + 1);
    localparam int DEPTH   = LINES * LINE_BYTES;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int IDLE_W  = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_TICK    = 2'd1,
        KIND_READ    = 2'd2,
        KIND_RELEASE = 2'd3
    } t_kind;

    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_TICKS = 1'b1;

    localparam logic [7:0]  GAP_TICKS_RST   = 8'd3;
    localparam logic [15:0] ERROR_TICKS_RST = 16'd200;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
        logic [4:0] read_index;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic [2:0] frames_pending;
        logic       comm_error;
    } t_out_item;

    // Byte address of a position inside a frame line.
    function automatic logic [ADDR_W-1:0] line_addr(input logic [LINE_W-1:0] line,
                                                   input logic [15:0] pos);
        int a;
        a = int'(line) * LINE_BYTES + int'(pos);
        return a[ADDR_W-1:0];
    endfunction

    function automatic logic [LINE_W-1:0] next_line(input logic [LINE_W-1:0] line);
        logic [LINE_W-1:0] last;
        last = LINE_W'(LINES - 1);
        return (line == last) ? '0 : line + 1'b1;
    endfunction

endpackage

// ===== rtl/core/idle_gap_frame_receiver.sv =====
// Idle gap frame receiver top level: frame line bookkeeping, idle timer and
// result pipeline. Depends on igfr_pkg and igfr_ram.
//
// Takes one transaction per clock unless input is stalled. Bytes are written
// into a ring of frame lines; ticks advance a saturating idle counter that
// commits the current line, if a line is free, after gap_ticks idle ticks
// and flags a communication error at error_ticks. Each transaction yields
// one result via the middle stage (beside the registered frame store RAM
// read) and the output register, which decouple the two channels: one more
// transaction is taken while a result waits, and input stalls once both hold
// a result and the output is stalled. The frame store needs no clearing
// pass: a never-written byte reads back as whatever the RAM holds.
module idle_gap_frame_receiver (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  igfr_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output igfr_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_we,
    input  logic [igfr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [igfr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // configuration
    logic [7:0]  r_gap_ticks;
    logic [15:0] r_error_ticks;

    // frame bookkeeping
    logic [igfr_pkg::LINE_W-1:0] r_write_line, n_write_line;
    logic [igfr_pkg::LINE_W-1:0] r_read_line,  n_read_line;
    logic [igfr_pkg::USED_W-1:0] r_used,       n_used;
    logic [igfr_pkg::POS_W-1:0]  r_write_pos,  n_write_pos;
    logic [igfr_pkg::IDLE_W-1:0] r_idle,       n_idle;
    logic                        r_armed,      n_armed;
    logic                        r_error,      n_error;

    // pipeline
    logic       r_s1_valid;
    logic       r_s1_is_read;
    logic [2:0] r_s1_pending;
    logic       r_s1_error;
    logic       r_out_valid;
    igfr_pkg::t_out_item r_out;

    logic in_ready, out_ready, accept;
    logic ram_we, ram_re;
    logic [igfr_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0] ram_rdata;
    logic [igfr_pkg::POS_W-1:0]  pos_clamped;
    logic [igfr_pkg::IDLE_W-1:0] idle_inc;
    logic read_ok;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign in_ready   = !r_s1_valid || out_ready;
    assign accept     = i_in_valid && in_ready;
    assign o_in_stall = !in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_ticks   <= igfr_pkg::GAP_TICKS_RST;
            r_error_ticks <= igfr_pkg::ERROR_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                igfr_pkg::CFG_GAP_TICKS:   r_gap_ticks   <= i_cfg_data[7:0];
                igfr_pkg::CFG_ERROR_TICKS: r_error_ticks <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_write_line = r_write_line;
        n_read_line  = r_read_line;
        n_used       = r_used;
        n_write_pos  = r_write_pos;
        n_idle       = r_idle;
        n_armed      = r_armed;
        n_error      = r_error;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        read_ok      = 1'b0;

        // clamp at the last slot so a long frame overwrites it
        pos_clamped = (r_write_pos >= igfr_pkg::POS_W'(igfr_pkg::LINE_BYTES))
                    ? igfr_pkg::POS_W'(igfr_pkg::LINE_BYTES - 1) : r_write_pos;
        idle_inc    = (r_idle != igfr_pkg::IDLE_MAX) ? r_idle + 1'b1 : r_idle;
        ram_waddr   = igfr_pkg::line_addr(r_write_line, 16'(pos_clamped));
        ram_raddr   = igfr_pkg::line_addr(r_read_line, 16'(i_in_data.read_index));

        if (accept) begin
            case (igfr_pkg::t_kind'(i_in_data.kind))
                igfr_pkg::KIND_BYTE: begin
                    n_idle      = '0;
                    n_armed     = 1'b1;
                    ram_we      = 1'b1;
                    n_write_pos = pos_clamped + 1'b1;
                end
                igfr_pkg::KIND_TICK: begin
                    n_idle = idle_inc;
                    if (r_armed && (idle_inc >= {8'd0, r_gap_ticks})) begin
                        n_armed = 1'b0;
                        // commit only when a line is free
                        if (r_used < igfr_pkg::USED_W'(igfr_pkg::LINES)) begin
                            n_used       = r_used + 1'b1;
                            n_write_line = igfr_pkg::next_line(r_write_line);
                            n_write_pos  = '0;
                        end
                    end
                    n_error = (idle_inc >= r_error_ticks);
                end
                igfr_pkg::KIND_READ: begin
                    read_ok = (r_used != '0) &&
                              (16'(i_in_data.read_index) < 16'(igfr_pkg::LINE_BYTES));
                    ram_re  = read_ok;
                end
                igfr_pkg::KIND_RELEASE: begin
                    if (r_used != '0) begin
                        n_used      = r_used - 1'b1;
                        n_read_line = igfr_pkg::next_line(r_read_line);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_line <= '0;
            r_read_line  <= '0;
            r_used       <= '0;
            r_write_pos  <= '0;
            r_idle       <= '0;
            r_armed      <= 1'b0;
            r_error      <= 1'b0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_write_line <= n_write_line;
            r_read_line  <= n_read_line;
            r_used       <= n_used;
            r_write_pos  <= n_write_pos;
            r_idle       <= n_idle;
            r_armed      <= n_armed;
            r_error      <= n_error;
            if (in_ready) begin
                r_s1_valid <= accept;
            end
            if (out_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_is_read <= read_ok;
            r_s1_pending <= 3'(n_used);
            r_s1_error   <= n_error;
        end
        if (out_ready && r_s1_valid) begin
            r_out.read_data      <= r_s1_is_read ? ram_rdata : 8'd0;
            r_out.frames_pending <= r_s1_pending;
            r_out.comm_error     <= r_s1_error;
        end
    end

    // the read data register holds while the middle stage is stalled,
    // since no new read is issued then
    igfr_ram #(
        .WIDTH (8),
        .DEPTH (igfr_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_in_data.rx_byte),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/core/igfr_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module igfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/igfr_checker.sv =====
// Port-level checks for the idle gap frame receiver, bound to the top level.
// Depends on igfr_pkg.
module igfr_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input igfr_pkg::t_in_item              i_in_data,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input igfr_pkg::t_out_item             o_out_data
);

    // a stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result changed while stalled");

    // a stalled input transaction holds its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=> (i_in_valid && $stable(i_in_data)))
        else $error("input changed while stalled");

    // input backs up only when a result is already waiting
    a_stall_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result waiting");

    a_pending_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.frames_pending <= 3'(igfr_pkg::LINES)))
        else $error("frames_pending beyond line count");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind idle_gap_frame_receiver igfr_checker u_igfr_checker (.*);

// ===== tb/sv/idle_gap_frame_receiver_test.sv =====
// Self-checking test of idle_gap_frame_receiver: directed and random
// transactions against a frame-ring scoreboard class. Depends on igfr_pkg.
`timescale 1ns / 100ps

module idle_gap_frame_receiver_test;

    localparam int CYCLE_LIMIT = 1_000_000;

    class frame_ring_scoreboard;
        logic [7:0]  line_bytes [igfr_pkg::DEPTH];
        bit          byte_written [igfr_pkg::DEPTH];
        logic [1:0]  wr_line;
        logic [1:0]  rd_line;
        logic [2:0]  used_lines;
        logic [5:0]  wr_pos;
        logic [15:0] idle_count;
        bit          gap_armed;
        bit          error_flag;
        logic [7:0]  gap_ticks;
        logic [15:0] error_ticks;
        igfr_pkg::t_out_item pending_results[$];
        int unsigned mismatches;

        function new();
            foreach (byte_written[a]) begin
                byte_written[a] = 1'b0;
                line_bytes[a] = 8'h00;
            end
            wr_line = '0;
            rd_line = '0;
            used_lines = '0;
            wr_pos = '0;
            idle_count = '0;
            gap_armed = 1'b0;
            error_flag = 1'b0;
            gap_ticks = igfr_pkg::GAP_TICKS_RST;
            error_ticks = igfr_pkg::ERROR_TICKS_RST;
            mismatches = 0;
        endfunction

        function void set_reg(logic [igfr_pkg::CFG_IDX_W-1:0] idx,
                              logic [igfr_pkg::CFG_DATA_W-1:0] value);
            if (idx == igfr_pkg::CFG_GAP_TICKS) begin
                gap_ticks = value[7:0];
            end else if (idx == igfr_pkg::CFG_ERROR_TICKS) begin
                error_ticks = value;
            end
        endfunction

        function logic [1:0] ring_next(logic [1:0] line);
            return (int'(line) == igfr_pkg::LINES - 1) ? 2'd0 : line + 2'd1;
        endfunction

        // Steer a read toward a byte of the oldest frame that holds data.
        function igfr_pkg::t_in_item safe_read(igfr_pkg::t_in_item it);
            int base;
            int picks[$];
            if (it.kind != igfr_pkg::KIND_READ || used_lines == 0) return it;
            base = int'(rd_line) * igfr_pkg::LINE_BYTES;
            if (byte_written[base + int'(it.read_index)]) return it;
            for (int p = 0; p < igfr_pkg::LINE_BYTES; p++) begin
                if (byte_written[base + p]) picks.push_back(p);
            end
            if (picks.size() != 0)
                it.read_index = 5'(picks[$urandom_range(picks.size() - 1)]);
            return it;
        endfunction

        function void take_item(igfr_pkg::t_in_item it);
            igfr_pkg::t_out_item res;
            int addr;
            res = '0;
            case (it.kind)
                igfr_pkg::KIND_BYTE: begin
                    idle_count = '0;
                    gap_armed = 1'b1;
                    if (wr_pos >= igfr_pkg::LINE_BYTES) wr_pos = 6'(igfr_pkg::LINE_BYTES - 1);
                    addr = int'(wr_line) * igfr_pkg::LINE_BYTES + int'(wr_pos);
                    line_bytes[addr] = it.rx_byte;
                    byte_written[addr] = 1'b1;
                    wr_pos = wr_pos + 6'd1;
                end
                igfr_pkg::KIND_TICK: begin
                    if (idle_count != igfr_pkg::IDLE_MAX) idle_count = idle_count + 16'd1;
                    if (gap_armed && idle_count >= gap_ticks) begin
                        gap_armed = 1'b0;
                        if (used_lines < igfr_pkg::LINES) begin
                            used_lines = used_lines + 3'd1;
                            wr_line = ring_next(wr_line);
                            wr_pos = '0;
                        end
                    end
                    error_flag = (idle_count >= error_ticks);
                end
                igfr_pkg::KIND_READ: begin
                    if (used_lines != 0)
                        res.read_data = line_bytes[int'(rd_line) * igfr_pkg::LINE_BYTES
                                                   + int'(it.read_index)];
                end
                default: begin
                    if (used_lines != 0) begin
                        used_lines = used_lines - 3'd1;
                        rd_line = ring_next(rd_line);
                    end
                end
            endcase
            res.frames_pending = used_lines;
            res.comm_error = error_flag;
            pending_results.push_back(res);
        endfunction

        task report(string what);
            if (mismatches < 40) $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(igfr_pkg::t_out_item got);
            igfr_pkg::t_out_item want;
            if (pending_results.size() == 0) begin
                report($sformatf("result %h with nothing outstanding", got));
                return;
            end
            want = pending_results.pop_front();
            if (got.read_data !== want.read_data)
                report($sformatf("read_data %h, want %h", got.read_data, want.read_data));
            if (got.frames_pending !== want.frames_pending)
                report($sformatf("frames_pending %0d, want %0d",
                                 got.frames_pending, want.frames_pending));
            if (got.comm_error !== want.comm_error)
                report($sformatf("comm_error %b, want %b", got.comm_error, want.comm_error));
        endtask
    endclass

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_stall;
    igfr_pkg::t_in_item              i_in_data = '0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    igfr_pkg::t_out_item             o_out_data;
    logic                            i_cfg_we = 1'b0;
    logic [igfr_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [igfr_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    frame_ring_scoreboard sb = new();
    bit calm = 1'b0;
    int items_sent = 0;
    int cycles = 0;

    idle_gap_frame_receiver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out_data);
        i_out_stall <= !calm && ($urandom_range(99) < 28);
    end

    // Present one transaction and hold it until it is taken.
    task automatic send_item(input igfr_pkg::t_kind k, input logic [7:0] b,
                             input logic [4:0] idx);
        igfr_pkg::t_in_item it;
        it.kind = k;
        it.rx_byte = b;
        it.read_index = idx;
        it = sb.safe_read(it);
        while (!calm && $urandom_range(99) < 28) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.take_item(it);
        items_sent++;
    endtask

    // Hold off input until every outstanding result is back.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_results.size() != 0);
    endtask

    task automatic write_regs(input logic [7:0] gap, input logic [15:0] err);
        logic [igfr_pkg::CFG_DATA_W-1:0] gap_word;
        gap_word = {8'($urandom), gap};
        drain();
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= igfr_pkg::CFG_GAP_TICKS;
        i_cfg_data <= gap_word;
        @(posedge i_clk);
        sb.set_reg(igfr_pkg::CFG_GAP_TICKS, gap_word);
        i_cfg_index <= igfr_pkg::CFG_ERROR_TICKS;
        i_cfg_data <= err;
        @(posedge i_clk);
        sb.set_reg(igfr_pkg::CFG_ERROR_TICKS, err);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly whole frames (bytes, a gap, some reads, maybe a release), some noise.
    task automatic random_traffic(input int count);
        int stop_at;
        int len;
        int ticks;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(39) == 0) drain();
            if ($urandom_range(99) < 80) begin
                len = ($urandom_range(7) == 0) ? $urandom_range(40, 28) : $urandom_range(8, 1);
                repeat (len) send_item(igfr_pkg::KIND_BYTE, 8'($urandom), 5'($urandom));
                ticks = int'(sb.gap_ticks) + $urandom_range(2);
                // leave the frame open now and then
                if ($urandom_range(5) == 0) ticks = int'(sb.gap_ticks) - 1;
                repeat (ticks) send_item(igfr_pkg::KIND_TICK, 8'($urandom), 5'($urandom));
                repeat ($urandom_range(4))
                    send_item(igfr_pkg::KIND_READ, 8'($urandom), 5'($urandom));
                if ($urandom_range(99) < 55)
                    send_item(igfr_pkg::KIND_RELEASE, 8'($urandom), 5'($urandom));
            end else begin
                repeat ($urandom_range(6, 1))
                    send_item(igfr_pkg::t_kind'($urandom_range(3)), 8'($urandom),
                              5'($urandom));
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_regs(8'd3, 16'd200);
        send_item(igfr_pkg::KIND_READ, 8'h00, 5'd31);
        send_item(igfr_pkg::KIND_RELEASE, 8'h00, 5'd0);
        send_item(igfr_pkg::KIND_TICK, 8'h00, 5'd0);
        send_item(igfr_pkg::KIND_BYTE, 8'h00, 5'd0);
        send_item(igfr_pkg::KIND_BYTE, 8'hFF, 5'd0);
        send_item(igfr_pkg::KIND_BYTE, 8'hA5, 5'd0);
        repeat (3) send_item(igfr_pkg::KIND_TICK, 8'h00, 5'd0);
        send_item(igfr_pkg::KIND_READ, 8'h00, 5'd0);
        send_item(igfr_pkg::KIND_READ, 8'h00, 5'd1);
        send_item(igfr_pkg::KIND_READ, 8'h00, 5'd2);
        send_item(igfr_pkg::KIND_BYTE, 8'h5A, 5'd0);
        repeat (3) send_item(igfr_pkg::KIND_TICK, 8'h00, 5'd0);
        send_item(igfr_pkg::KIND_RELEASE, 8'h00, 5'd0);
        send_item(igfr_pkg::KIND_READ, 8'h00, 5'd0);
        send_item(igfr_pkg::KIND_RELEASE, 8'h00, 5'd0);
        send_item(igfr_pkg::KIND_READ, 8'h00, 5'd0);

        write_regs(8'd1, 16'd1);
        random_traffic(150);

        write_regs(8'd2, 16'd5);
        calm = 1'b1;
        random_traffic(150);
        calm = 1'b0;

        write_regs(8'd255, 16'd256);
        random_traffic(100);

        // idle counter runs past the error threshold while the flag stays up
        write_regs(8'd2, 16'd30);
        repeat (3) send_item(igfr_pkg::KIND_BYTE, 8'($urandom), 5'd0);
        repeat (40) send_item(igfr_pkg::KIND_TICK, 8'($urandom), 5'($urandom));
        send_item(igfr_pkg::KIND_READ, 8'h00, 5'($urandom));
        send_item(igfr_pkg::KIND_RELEASE, 8'h00, 5'd0);

        write_regs(8'($urandom_range(6, 1)), 16'($urandom_range(40, 1)));
        random_traffic(250);

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.pending_results.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending_results.size()));
        if (sb.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
